FILE: rtl/core/fvn_pkg.sv
`default_nettype none
package fvn_pkg;

    localparam int MAX_OCTAVES_DEF = 8;
    localparam int FRAC_BITS_DEF   = 16;

    localparam logic [1:0] REG_SEED   = 2'd0;
    localparam logic [1:0] REG_OCTAVE = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    localparam logic [31:0] HK1 = 32'h9E3779B1;
    localparam logic [31:0] HK2 = 32'h85EBCA77;
    localparam logic [31:0] HK3 = 32'h2C1B3C6D;
    localparam logic [31:0] HK4 = 32'h297A2D39;

    localparam logic [31:0] STEP_PLAIN = 32'd101;
    localparam logic [31:0] STEP_RIDGE = 32'd313;

    localparam logic [17:0] C0_PLAIN = 18'd105382;
    localparam logic [17:0] C1_PLAIN = 18'd79036;
    localparam logic [17:0] C0_RIDGE = 18'd106430;
    localparam logic [17:0] C1_RIDGE = 18'd79823;

    localparam logic [31:0] OX_PLAIN = 32'd1133773;
    localparam logic [31:0] OZ_PLAIN = 32'd602931;
    localparam logic [31:0] OX_RIDGE = 32'd334234;
    localparam logic [31:0] OZ_RIDGE = 32'd897843;

    // floor(2^32 / (2^k - 1)), k = 1..16
    function automatic logic [32:0] recip_of(input logic [4:0] k);
        logic [32:0] r;
        case (k)
            5'd1:    r = 33'h100000000;
            5'd2:    r = 33'd1431655765;
            5'd3:    r = 33'd613566756;
            5'd4:    r = 33'd286331153;
            5'd5:    r = 33'd138547332;
            5'd6:    r = 33'd68174084;
            5'd7:    r = 33'd33818640;
            5'd8:    r = 33'd16843009;
            5'd9:    r = 33'd8405024;
            5'd10:   r = 33'd4198404;
            5'd11:   r = 33'd2098176;
            5'd12:   r = 33'd1048832;
            5'd13:   r = 33'd524352;
            5'd14:   r = 33'd262160;
            5'd15:   r = 33'd131076;
            5'd16:   r = 33'd65537;
            default: r = 33'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/fractal_value_noise_2d_unit.sv
`default_nettype none
// Request path: the octave sections, the normalize stages, then the output register.
// One request per cycle unless the output stalls; each octave is an 8-stage section.
// A stalled output freezes the whole pipeline; one output register holds the result.
// Reset (aresetn, synchronous): seed 0, octaves 4, plain mode, pipeline empty.
module fractal_value_noise_2d_unit #(
    parameter int MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF,
    parameter int FRAC_BITS   = fvn_pkg::FRAC_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // coord_x [31:0], coord_z [63:32]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // noise_value [15:0]
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import fvn_pkg::*;

    localparam int OW  = $clog2(MAX_OCTAVES + 1);
    localparam int AW  = 24 + MAX_OCTAVES;
    localparam int SBW = AW + OW + 32;

    logic [31:0] seed_reg;
    logic [3:0]  oct_reg;
    logic        mode_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
            oct_reg  <= 4'd4;
            mode_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SEED:   seed_reg <= cfg_data;
                REG_OCTAVE: oct_reg  <= cfg_data[3:0];
                REG_MODE:   mode_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    logic [OW-1:0] k_eff;
    always_comb begin
        if (oct_reg == 4'd0)
            k_eff = OW'(1);
        else if (32'(oct_reg) > 32'(MAX_OCTAVES))
            k_eff = OW'(MAX_OCTAVES);
        else
            k_eff = OW'(oct_reg);
    end

    // advance everything unless a held result is refused
    logic        res_v_reg;
    logic [15:0] res_d_reg;
    logic        en, fin_v;
    logic [15:0] fin_d;
    assign en = !res_v_reg || m_tready;
    assign s_tready = en;

    logic          v   [MAX_OCTAVES+1];
    logic [31:0]   xs  [MAX_OCTAVES+1];
    logic [31:0]   zs  [MAX_OCTAVES+1];
    logic [SBW-1:0] sb [MAX_OCTAVES+1];

    assign v[0]  = s_tvalid;
    assign xs[0] = s_tdata[31:0];
    assign zs[0] = s_tdata[63:32];
    assign sb[0] = {seed_reg, k_eff, AW'(0)};

    // sideband: {seed, k, acc}
    for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_oct
        logic          ov;
        logic [31:0]   ox, oz;
        logic [24:0]   on;
        logic [SBW-1:0] osb;
        logic [31:0]   seed_i;
        assign seed_i = sb[g][SBW-1 -: 32] + 32'(g) * (mode_reg ? STEP_RIDGE : STEP_PLAIN);
        fvn_octave #(.FRAC_BITS(FRAC_BITS), .SB_W(SBW)) u_oct (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .in_valid(v[g]), .in_x(xs[g]), .in_z(zs[g]),
            .in_seed(seed_i), .in_ridged(mode_reg), .in_sb(sb[g]),
            .out_valid(ov), .out_x(ox), .out_z(oz), .out_n(on), .out_sb(osb)
        );
        logic [SBW-1:0] nsb;
        logic [OW-1:0]  k2;
        logic [AW-1:0]  a2;
        logic [31:0]    s2;
        assign {s2, k2, a2} = osb;
        // add only while octave index is below k, weight 2^(k-1-i)
        always_comb begin
            nsb = osb;
            if (32'(g) < 32'(k2))
                nsb = {s2, k2, a2 + (AW'(on) << (k2 - OW'(1) - OW'(g)))};
        end
        assign v[g+1]  = ov;
        assign xs[g+1] = ox;
        assign zs[g+1] = oz;
        assign sb[g+1] = nsb;
    end

    // normalize: mult 33xAW split into two stages
    logic [AW-1:0] acc_f;
    logic [OW-1:0] k_f;
    assign acc_f = sb[MAX_OCTAVES][AW-1:0];
    assign k_f   = sb[MAX_OCTAVES][AW+OW-1:AW];
    logic          n1v_reg, n2v_reg;
    logic [AW+32:0] lo_reg;
    logic [AW-1:0] ac_reg;
    logic          hi_reg;
    logic [AW+32:0] prod_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n1v_reg <= 1'b0;
            n2v_reg <= 1'b0;
        end else if (en) begin
            n1v_reg <= v[MAX_OCTAVES];
            n2v_reg <= n1v_reg;
        end
    end
    logic [32:0] rc;
    assign rc = recip_of(5'(k_f));
    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg   <= (AW+33)'(acc_f) * (AW+33)'(rc[31:0]);
            hi_reg   <= rc[32];
            ac_reg   <= acc_f;
            prod_reg <= lo_reg + (hi_reg ? ((AW+33)'(ac_reg) << 32) : '0);
        end
    end
    assign fin_v = n2v_reg;
    assign fin_d = ((prod_reg >> 40) > (AW+33)'(16'hFFFF)) ? 16'hFFFF : 16'(prod_reg >> 40);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_v_reg <= 1'b0;
        end else if (en) begin
            res_v_reg <= fin_v;
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            res_d_reg <= fin_d;
        end
    end
    assign m_tvalid = res_v_reg;
    assign m_tdata  = res_d_reg;
endmodule
`default_nettype wire

FILE: rtl/core/fvn_octave.sv
`default_nettype none
// One octave, eight register stages. Sideband (acc, config) rides along.
module fvn_octave #(
    parameter int FRAC_BITS = fvn_pkg::FRAC_BITS_DEF,
    parameter int SB_W      = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [31:0]      in_x,
    input  wire logic [31:0]      in_z,
    input  wire logic [31:0]      in_seed,
    input  wire logic             in_ridged,
    input  wire logic [SB_W-1:0]  in_sb,
    output logic                  out_valid,
    output logic [31:0]           out_x,
    output logic [31:0]           out_z,
    output logic [24:0]           out_n,
    output logic [SB_W-1:0]       out_sb
);
    import fvn_pkg::*;

    localparam int NS = 8;
    localparam int FW = FRAC_BITS;
    localparam logic [FW:0] ONE = {1'b1, {FW{1'b0}}};
    localparam logic [31:0] OXP = 32'((64'(OX_PLAIN) << FW) >> 16);
    localparam logic [31:0] OZP = 32'((64'(OZ_PLAIN) << FW) >> 16);
    localparam logic [31:0] OXR = 32'((64'(OX_RIDGE) << FW) >> 16);
    localparam logic [31:0] OZR = 32'((64'(OZ_RIDGE) << FW) >> 16);

    logic [NS-1:0]   v_reg;
    logic [SB_W-1:0] sb_reg [NS];
    logic            rd_reg [NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_reg[0] <= in_sb;
            rd_reg[0] <= in_ridged;
            for (int i = 1; i < NS; i++) begin
                sb_reg[i] <= sb_reg[i-1];
                rd_reg[i] <= rd_reg[i-1];
            end
        end
    end

    // ---- hash chain: stage 0 base, 1 mul3, 2 mul4, 3 mix
    logic [31:0] ix, iz, hb_reg [4];
    logic [FW-1:0] tx_reg, tz_reg;
    assign ix = 32'($signed(in_x) >>> FW);
    assign iz = 32'($signed(in_z) >>> FW);

    logic [31:0] h0 [4], h1 [4], h2 [4];
    logic [31:0] m3_reg [4], m4_reg [4];
    logic [23:0] cor_reg [4];
    logic [31:0] ixm, izm;
    always_comb begin
        ixm = ix * HK1;
        izm = iz * HK2;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            hb_reg[0] <= in_seed + ixm + izm;
            hb_reg[1] <= in_seed + ixm + HK1 + izm;
            hb_reg[2] <= in_seed + ixm + izm + HK2;
            hb_reg[3] <= in_seed + ixm + HK1 + izm + HK2;
            tx_reg <= in_x[FW-1:0];
            tz_reg <= in_z[FW-1:0];
        end
    end
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            h0[c] = hb_reg[c] ^ (hb_reg[c] >> 15);
            h1[c] = m3_reg[c] ^ (m3_reg[c] >> 12);
            h2[c] = m4_reg[c] ^ (m4_reg[c] >> 15);
        end
    end

    // smoothstep weights in parallel
    logic [2*FW-1:0] t2x_reg, t2z_reg, t2x1_reg, t2z1_reg;
    logic [FW+1:0]   kx_reg, kz_reg;
    logic [FW:0]     sx_reg, sz_reg;
    logic [FW:0]     sz2_reg;
    logic [FW-1:0]   tx1_reg, tz1_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                m3_reg[c] <= h0[c] * HK3;
                m4_reg[c] <= h1[c] * HK4;
                cor_reg[c] <= h2[c][23:0];
            end
            tx1_reg <= tx_reg;
            tz1_reg <= tz_reg;
            t2x_reg <= (2*FW)'(tx_reg) * (2*FW)'(tx_reg);
            t2z_reg <= (2*FW)'(tz_reg) * (2*FW)'(tz_reg);
            // hold t*t one stage so it meets 3-2t
            t2x1_reg <= t2x_reg;
            t2z1_reg <= t2z_reg;
            kx_reg  <= (FW+2)'(3 * ONE) - (FW+2)'({tx1_reg, 1'b0});
            kz_reg  <= (FW+2)'(3 * ONE) - (FW+2)'({tz1_reg, 1'b0});
            sx_reg  <= (FW+1)'(((2*FW+2)'(t2x1_reg >> FW) * (2*FW+2)'(kx_reg)) >> FW);
            sz_reg  <= (FW+1)'(((2*FW+2)'(t2z1_reg >> FW) * (2*FW+2)'(kz_reg)) >> FW);
            sz2_reg <= sz_reg;
        end
    end

    // blend stage: corners valid at s4, sx at s4 (t2x s2,kx s3,sx s4)
    logic [23:0] ab_reg, cd_reg, n0_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            ab_reg <= 24'(((FW+25)'(cor_reg[0]) * (FW+25)'(ONE - sx_reg)
                          + (FW+25)'(cor_reg[1]) * (FW+25)'(sx_reg)) >> FW);
            cd_reg <= 24'(((FW+25)'(cor_reg[2]) * (FW+25)'(ONE - sx_reg)
                          + (FW+25)'(cor_reg[3]) * (FW+25)'(sx_reg)) >> FW);
            n0_reg <= 24'(((FW+25)'(ab_reg) * (FW+25)'(ONE - sz2_reg)
                          + (FW+25)'(cd_reg) * (FW+25)'(sz2_reg)) >> FW);
        end
    end

    // ridged shaping: fold at s7, square at s8 (a full-scale fold squares to 1.0)
    logic [24:0] dev, r, r_reg;
    logic [23:0] n1_reg;
    logic [24:0] n_reg;
    always_comb begin
        dev = ({n0_reg, 1'b0} >= 25'h1000000) ? {n0_reg, 1'b0} - 25'h1000000
                                              : 25'h1000000 - {n0_reg, 1'b0};
        r   = 25'h1000000 - dev;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg  <= r;
            n1_reg <= n0_reg;
            n_reg  <= rd_reg[6] ? 25'((50'(r_reg) * 50'(r_reg)) >> 24) : 25'(n1_reg);
        end
    end

    // domain step: mul at s0->s1, add/shift at s1->s2
    logic signed [50:0] pxa_reg, pxb_reg, pza_reg, pzb_reg;
    logic [31:0] nx_reg [1:NS-1], nz_reg [1:NS-1];
    logic signed [51:0] sumx, sumz;
    always_ff @(posedge aclk) begin
        if (en) begin
            pxa_reg <= $signed(in_x) * $signed({1'b0, in_ridged ? C0_RIDGE : C0_PLAIN});
            pxb_reg <= $signed(in_z) * $signed({1'b0, in_ridged ? C1_RIDGE : C1_PLAIN});
            pza_reg <= $signed(in_x) * $signed({1'b0, in_ridged ? C1_RIDGE : C1_PLAIN});
            pzb_reg <= $signed(in_z) * $signed({1'b0, in_ridged ? C0_RIDGE : C0_PLAIN});
        end
    end
    always_comb begin
        sumx = 52'(pxa_reg) - 52'(pxb_reg);
        sumz = 52'(pza_reg) + 52'(pzb_reg);
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg[1] <= 32'(sumx >>> 16) + (rd_reg[0] ? OXR : OXP);
            nz_reg[1] <= 32'(sumz >>> 16) + (rd_reg[0] ? OZR : OZP);
            for (int i = 2; i < NS; i++) begin
                nx_reg[i] <= nx_reg[i-1];
                nz_reg[i] <= nz_reg[i-1];
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_x     = nx_reg[NS-1];
    assign out_z     = nz_reg[NS-1];
    assign out_n     = n_reg;
    assign out_sb    = sb_reg[NS-1];
endmodule
`default_nettype wire
